[design/rsa_pkg.sv]
// Shared types, codes and constants of the RPN stack ALU.
`default_nettype none
package rsa_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int OP_W        = 4;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_W     = 5;
    localparam int LN_TAB_N    = 30;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_LN   = 4'd5,
        OP_LOG  = 4'd6,
        OP_PI   = 4'd7,
        OP_E    = 4'd8
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_UNDER   = 3'd1,
        STAT_OVER    = 3'd2,
        STAT_DIVZERO = 3'd3,
        STAT_BADLN   = 3'd4,
        STAT_BADLOG  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        SRC_VALUE,
        SRC_PI,
        SRC_E,
        SRC_SUM,
        SRC_DIFF,
        SRC_PROD,
        SRC_QUOT,
        SRC_K
    } t_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_T,
        S_RD_S,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_LOG_CHK,
        S_LN,
        S_TOP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    push;
        t_src    src;
        logic    pop;
        logic    rd;
        logic    lat_t;
        logic    lat_s;
        logic    set_stat;
        t_status stat;
        logic    init_mul;
        logic    init_logmul;
        logic    init_div;
        logic    init_log;
        logic    init_ln;
        logic    step_mul;
        logic    step_div;
        logic    step_ln;
        logic    log_upd;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic sp_zero;
        logic sp_one;
        logic sp_full;
        logic t_zero;
        logic t_nonpos;
        logic log_bad;
        logic cnt_done;
        logic log_more;
        logic ln_more;
        logic out_free;
    } t_stat;

    // Floor of e raised to the power k+1; all ones past the end of the table.
    function automatic logic [63:0] ln_thr(input logic [5:0] k);
        logic [63:0] v;
        case (k)
            6'd0:    v = 64'd2;
            6'd1:    v = 64'd7;
            6'd2:    v = 64'd20;
            6'd3:    v = 64'd54;
            6'd4:    v = 64'd148;
            6'd5:    v = 64'd403;
            6'd6:    v = 64'd1096;
            6'd7:    v = 64'd2980;
            6'd8:    v = 64'd8103;
            6'd9:    v = 64'd22026;
            6'd10:   v = 64'd59874;
            6'd11:   v = 64'd162754;
            6'd12:   v = 64'd442413;
            6'd13:   v = 64'd1202604;
            6'd14:   v = 64'd3269017;
            6'd15:   v = 64'd8886110;
            6'd16:   v = 64'd24154952;
            6'd17:   v = 64'd65659969;
            6'd18:   v = 64'd178482300;
            6'd19:   v = 64'd485165195;
            6'd20:   v = 64'd1318815734;
            6'd21:   v = 64'd3584912846;
            6'd22:   v = 64'd9744803446;
            6'd23:   v = 64'd26489122129;
            6'd24:   v = 64'd72004899337;
            6'd25:   v = 64'd195729609428;
            6'd26:   v = 64'd532048240601;
            6'd27:   v = 64'd1446257064291;
            6'd28:   v = 64'd3931334297144;
            6'd29:   v = 64'd10686474581524;
            default: v = '1;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/rsa_ctrl.sv]
// Controller state machine that sequences stack accesses and ALU iterations.
`default_nettype none
module rsa_ctrl
    import rsa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_LN: begin
                        n_state = i_stat.sp_zero ? S_TOP : S_RD_T;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOG: begin
                        n_state = (i_stat.sp_zero || i_stat.sp_one) ? S_TOP : S_RD_T;
                    end
                    default: n_state = S_TOP;
                endcase
            end
            S_RD_T: n_state = (i_stat.op == OP_LN) ? S_EXEC : S_RD_S;
            S_RD_S: n_state = S_EXEC;
            S_EXEC: begin
                case (i_stat.op)
                    OP_MUL: n_state = S_MUL;
                    OP_DIV: n_state = i_stat.t_zero ? S_TOP : S_DIV;
                    OP_LOG: n_state = i_stat.log_bad ? S_TOP : S_DIV;
                    OP_LN:  n_state = i_stat.t_nonpos ? S_TOP : S_LN;
                    default: n_state = S_TOP;
                endcase
            end
            S_MUL: begin
                if (i_stat.cnt_done) begin
                    n_state = (i_stat.op == OP_LOG) ? S_LOG_CHK : S_TOP;
                end
            end
            S_DIV: begin
                if (i_stat.cnt_done) begin
                    n_state = (i_stat.op == OP_LOG) ? S_LOG_CHK : S_TOP;
                end
            end
            S_LOG_CHK: n_state = i_stat.log_more ? S_MUL : S_TOP;
            S_LN: begin
                if (!i_stat.ln_more) begin
                    n_state = S_TOP;
                end
            end
            S_TOP: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.src  = SRC_VALUE;
        o_cmd.stat = STAT_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.set_stat = 1'b1;
                case (i_stat.op)
                    OP_PUSH, OP_PI, OP_E: begin
                        if (i_stat.sp_full) begin
                            o_cmd.stat = STAT_OVER;
                        end else begin
                            o_cmd.push = 1'b1;
                            o_cmd.src  = (i_stat.op == OP_PI) ? SRC_PI :
                                         (i_stat.op == OP_E)  ? SRC_E  : SRC_VALUE;
                        end
                    end
                    OP_LN: begin
                        if (i_stat.sp_zero) begin
                            o_cmd.stat = STAT_UNDER;
                        end else begin
                            o_cmd.rd  = 1'b1;
                            o_cmd.pop = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOG: begin
                        if (i_stat.sp_zero) begin
                            o_cmd.stat = STAT_UNDER;
                        end else if (i_stat.sp_one) begin
                            o_cmd.stat = STAT_UNDER;
                            o_cmd.pop  = 1'b1;
                        end else begin
                            o_cmd.rd  = 1'b1;
                            o_cmd.pop = 1'b1;
                        end
                    end
                    default: o_cmd.stat = STAT_OK;
                endcase
            end
            S_RD_T: begin
                o_cmd.lat_t = 1'b1;
                if (i_stat.op != OP_LN) begin
                    o_cmd.rd  = 1'b1;
                    o_cmd.pop = 1'b1;
                end
            end
            S_RD_S: o_cmd.lat_s = 1'b1;
            S_EXEC: begin
                case (i_stat.op)
                    OP_ADD: begin
                        o_cmd.push = 1'b1;
                        o_cmd.src  = SRC_SUM;
                    end
                    OP_SUB: begin
                        o_cmd.push = 1'b1;
                        o_cmd.src  = SRC_DIFF;
                    end
                    OP_MUL: o_cmd.init_mul = 1'b1;
                    OP_DIV: begin
                        if (i_stat.t_zero) begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat     = STAT_DIVZERO;
                        end else begin
                            o_cmd.init_div = 1'b1;
                        end
                    end
                    OP_LOG: begin
                        if (i_stat.log_bad) begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat     = STAT_BADLOG;
                        end else begin
                            o_cmd.init_div = 1'b1;
                        end
                    end
                    OP_LN: begin
                        if (i_stat.t_nonpos) begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat     = STAT_BADLN;
                        end else begin
                            o_cmd.init_ln = 1'b1;
                        end
                    end
                    default: o_cmd.push = 1'b0;
                endcase
            end
            S_MUL: begin
                if (!i_stat.cnt_done) begin
                    o_cmd.step_mul = 1'b1;
                end else if (i_stat.op == OP_LOG) begin
                    o_cmd.log_upd = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src  = SRC_PROD;
                end
            end
            S_DIV: begin
                if (!i_stat.cnt_done) begin
                    o_cmd.step_div = 1'b1;
                end else if (i_stat.op == OP_LOG) begin
                    o_cmd.init_log = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src  = SRC_QUOT;
                end
            end
            S_LOG_CHK: begin
                if (i_stat.log_more) begin
                    o_cmd.init_logmul = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src  = SRC_K;
                end
            end
            S_LN: begin
                if (i_stat.ln_more) begin
                    o_cmd.step_ln = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src  = SRC_K;
                end
            end
            S_TOP: o_cmd.rd = 1'b1;
            S_OUT: o_cmd.out_load = i_stat.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

[design/rsa_dp.sv]
// Datapath: operand stack memory, shift-add multiplier, restoring divider,
// log iterators and the result register.
`default_nettype none
module rsa_dp
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [VALUE_W-1:0]        o_top_value,
    output logic                      o_top_valid,
    output logic [DEPTH_W-1:0]        o_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(DATA_WIDTH + 1);
    localparam int KW = $clog2(DATA_WIDTH);
    localparam int DW = DATA_WIDTH;

    logic [DW-1:0] r_mem [STACK_DEPTH];
    logic [DW-1:0] r_rdata;
    logic [PW-1:0] r_sp;
    logic [OP_W-1:0] r_op;
    logic [DW-1:0] r_val, r_t, r_s;
    logic [DW-1:0] r_acc, r_mb, r_mt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_p;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_cnt;
    t_status       r_stat;
    logic          r_ovalid;
    logic [STATUS_W-1:0] r_o_stat;
    logic [VALUE_W-1:0]  r_o_top;
    logic                r_o_tv;
    logic [DEPTH_W-1:0]  r_o_depth;

    logic [DW-1:0] mag_t, mag_s, quot, wdata;
    logic [DW:0]   div_sh;
    logic          div_ge;
    logic [AW-1:0] rd_addr, wr_addr;

    assign mag_t   = r_t[DW-1] ? (~r_t + 1'b1) : r_t;
    assign mag_s   = r_s[DW-1] ? (~r_s + 1'b1) : r_s;
    assign quot    = (r_s[DW-1] ^ r_t[DW-1]) ? (~r_quo + 1'b1) : r_quo;
    assign div_sh  = {r_rem, r_quo[DW-1]};
    assign div_ge  = div_sh >= {1'b0, mag_t};
    assign rd_addr = AW'(r_sp - 1'b1);
    assign wr_addr = AW'(r_sp);

    always_comb begin
        case (i_cmd.src)
            SRC_VALUE: wdata = r_val;
            SRC_PI:    wdata = DW'(3);
            SRC_E:     wdata = DW'(2);
            SRC_SUM:   wdata = r_s + r_t;
            SRC_DIFF:  wdata = r_s - r_t;
            SRC_PROD:  wdata = r_acc;
            SRC_QUOT:  wdata = quot;
            SRC_K:     wdata = DW'(r_k);
            default:   wdata = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_val <= DW'(i_value);
        end
        if (i_cmd.lat_t) begin
            r_t <= r_rdata;
        end
        if (i_cmd.lat_s) begin
            r_s <= r_rdata;
        end
        if (i_cmd.set_stat || i_cmd.push) begin
            r_stat <= i_cmd.set_stat ? i_cmd.stat : STAT_OK;
        end
        // Multiplier and divider share the bit counter.
        if (i_cmd.init_mul || i_cmd.init_logmul) begin
            r_acc <= '0;
            r_mb  <= i_cmd.init_mul ? r_s : r_p;
            r_mt  <= r_t;
            r_cnt <= CW'(DW);
        end else if (i_cmd.step_mul) begin
            r_acc <= r_mt[0] ? (r_acc + r_mb) : r_acc;
            r_mb  <= {r_mb[DW-2:0], 1'b0};
            r_mt  <= {1'b0, r_mt[DW-1:1]};
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.init_div) begin
            r_rem <= '0;
            r_quo <= mag_s;
            r_cnt <= CW'(DW);
        end else if (i_cmd.step_div) begin
            r_rem <= div_ge ? DW'(div_sh - {1'b0, mag_t}) : div_sh[DW-1:0];
            r_quo <= {r_quo[DW-2:0], div_ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.init_log) begin
            r_p <= DW'(1);
            r_k <= '0;
        end else if (i_cmd.log_upd) begin
            r_p <= r_acc;
            r_k <= r_k + 1'b1;
        end else if (i_cmd.init_ln) begin
            r_k <= '0;
        end else if (i_cmd.step_ln) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_stat  <= r_stat;
            r_o_top   <= (r_sp != '0) ? VALUE_W'(r_rdata) : '0;
            r_o_tv    <= (r_sp != '0);
            r_o_depth <= DEPTH_W'(r_sp);
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.op       = t_op'(r_op);
        o_stat.sp_zero  = (r_sp == '0);
        o_stat.sp_one   = (r_sp == PW'(1));
        o_stat.sp_full  = (r_sp == PW'(STACK_DEPTH));
        o_stat.t_zero   = (r_t == '0);
        o_stat.t_nonpos = (r_t == '0) || r_t[DW-1];
        o_stat.log_bad  = (r_s == '0) || r_s[DW-1] || r_t[DW-1] || (r_t < DW'(2));
        o_stat.cnt_done = (r_cnt == '0);
        o_stat.log_more = (r_p <= r_quo);
        o_stat.ln_more  = (64'(r_t) > ln_thr(6'(r_k)));
        o_stat.out_free = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_o_stat;
    assign o_top_value = r_o_top;
    assign o_top_valid = r_o_tv;
    assign o_depth     = r_o_depth;

endmodule
`default_nettype wire

[design/rpn_stack_alu.sv]
// Top level of the RPN stack ALU: stream ports around controller and datapath.
`default_nettype none
// Each input transaction either pushes a value (or the constant 3 or 2) or
// runs one operation on the top of a signed operand stack; every transaction
// returns exactly one result with a status code, the new top entry and the
// depth. Multiply and divide use a shift-add multiplier and a restoring
// divider, each handling one bit per cycle. Integer log runs a divide and
// then one multiply pass per unit of the result; natural log takes one step
// per unit of the result. Underflow and operand errors end the transaction
// without running the arithmetic, and a stalled result holds the block until
// it is taken. One transaction is in work at a time; the next is taken once
// the result sits in the output register.
module rpn_stack_alu
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // op [3:0], value [35:4], zero fill [39:36]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status [2:0], top_value [34:3], top_valid [35], depth [40:36], zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    t_cmd  cmd;
    t_stat stat;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  top_value;
    logic                top_valid;
    logic [DEPTH_W-1:0]  depth;

    rsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rsa_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tdata[3:0]),
        .i_value     (s_axis_tdata[35:4]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (status),
        .o_top_value (top_value),
        .o_top_valid (top_valid),
        .o_depth     (depth)
    );

    assign m_axis_tdata = {7'd0, depth, top_valid, top_value, status};

endmodule
`default_nettype wire

[design/rsa_checker.sv]
// Port-level checker for the RPN stack ALU and its bind to the top level.
`default_nettype none
module rsa_checker
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while one is in work");

    a_valid_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[35] == (m_axis_tdata[40:36] != 5'd0)))
        else $error("top_valid disagrees with depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[35] |-> m_axis_tdata[34:3] == 32'd0)
        else $error("empty stack shows a nonzero top");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[40:36]) <= STACK_DEPTH)
                          && (m_axis_tdata[2:0] <= STAT_BADLOG))
        else $error("depth or status out of range");

endmodule

bind rpn_stack_alu rsa_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[sim/tb.sv]
// Testbench for rpn_stack_alu: random stack programs checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none

// Holds the stack predictor and the queue of expected stack reports.
class stack_scoreboard;
    bit [31:0] stack_mem[16];
    int unsigned stack_depth;
    bit [47:0] report_q[$];
    int unsigned fail_count;
    int unsigned report_count;

    function void clear();
        stack_depth = 0;
        foreach (stack_mem[i]) stack_mem[i] = '0;
    endfunction

    function bit [31:0] ln_floor(bit [31:0] x);
        bit [31:0] k;
        k = 0;
        while (k < rsa_pkg::LN_TAB_N && {32'd0, x} > rsa_pkg::ln_thr(k[5:0])) k++;
        return k;
    endfunction

    function bit [31:0] log_floor(bit [31:0] a, bit [31:0] b);
        longint unsigned p, lim;
        bit [31:0] k;
        p = 1;
        k = 0;
        lim = a / b;
        while (p <= lim) begin
            p = p * b;
            k++;
        end
        return k;
    endfunction

    function bit [2:0] push_word(bit [31:0] v);
        if (stack_depth >= 16) return rsa_pkg::STAT_OVER;
        stack_mem[stack_depth] = v;
        stack_depth++;
        return rsa_pkg::STAT_OK;
    endfunction

    function bit [2:0] exec(bit [3:0] op, bit [31:0] v);
        bit [31:0] t, s, q;
        if (op == rsa_pkg::OP_PUSH) return push_word(v);
        if (op == rsa_pkg::OP_PI) return push_word(32'd3);
        if (op == rsa_pkg::OP_E) return push_word(32'd2);
        if (op == rsa_pkg::OP_LN) begin
            if (stack_depth == 0) return rsa_pkg::STAT_UNDER;
            stack_depth--;
            t = stack_mem[stack_depth];
            if ($signed(t) <= 0) return rsa_pkg::STAT_BADLN;
            return push_word(ln_floor(t));
        end
        if (op inside {rsa_pkg::OP_ADD, rsa_pkg::OP_SUB, rsa_pkg::OP_MUL,
                       rsa_pkg::OP_DIV, rsa_pkg::OP_LOG}) begin
            if (stack_depth == 0) return rsa_pkg::STAT_UNDER;
            stack_depth--;
            t = stack_mem[stack_depth];
            if (stack_depth == 0) return rsa_pkg::STAT_UNDER;
            stack_depth--;
            s = stack_mem[stack_depth];
            case (op)
                rsa_pkg::OP_ADD: return push_word(s + t);
                rsa_pkg::OP_SUB: return push_word(s - t);
                rsa_pkg::OP_MUL: return push_word(s * t);
                rsa_pkg::OP_DIV: begin
                    if (t == 0) return rsa_pkg::STAT_DIVZERO;
                    q = (s[31] ? -s : s) / (t[31] ? -t : t);
                    return push_word((s[31] != t[31]) ? -q : q);
                end
                default: begin
                    if ($signed(s) <= 0 || $signed(t) < 2) return rsa_pkg::STAT_BADLOG;
                    return push_word(log_floor(s, t));
                end
            endcase
        end
        return rsa_pkg::STAT_OK;
    endfunction

    function void note_request(bit [3:0] op, bit [31:0] v);
        bit [2:0] st;
        bit [31:0] top;
        st = exec(op, v);
        top = (stack_depth > 0) ? stack_mem[stack_depth - 1] : 32'd0;
        report_q.push_back({7'd0, stack_depth[4:0], stack_depth != 0, top, st});
    endfunction

    function void check_report(bit [47:0] got);
        bit [47:0] e;
        report_count++;
        if (report_q.size() == 0) begin
            $display("%0t: unexpected report %h", $time, got);
            fail_count++;
            return;
        end
        e = report_q.pop_front();
        if (got[2:0] !== e[2:0]) begin
            $display("%0t: status expected %0d actual %0d", $time, e[2:0], got[2:0]);
            fail_count++;
        end
        if (got[34:3] !== e[34:3]) begin
            $display("%0t: top_value expected %h actual %h", $time, e[34:3], got[34:3]);
            fail_count++;
        end
        if (got[35] !== e[35]) begin
            $display("%0t: top_valid expected %b actual %b", $time, e[35], got[35]);
            fail_count++;
        end
        if (got[40:36] !== e[40:36]) begin
            $display("%0t: depth expected %0d actual %0d", $time, e[40:36], got[40:36]);
            fail_count++;
        end
    endfunction
endclass

module tb;
    import rsa_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // op [3:0], value [35:4], zero fill [39:36]
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // status [2:0], top_value [34:3], top_valid [35], depth [40:36], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    stack_scoreboard board;
    longint unsigned cycle_count;
    int unsigned sent_count;
    int unsigned stall_mode;

    rpn_stack_alu DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        board.clear();
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_rst_n = 1'b0;
        cycle_count = 0;
        sent_count = 0;
        stall_mode = 0;
    end

    // Receiver: picks a random stall pattern at regular intervals, including no stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= (cycle_count[3:0] < 4'd5);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_report(m_axis_tdata);
        if (cycle_count > 20000000) begin
            $display("rpn_stack_alu verification failed");
            $finish;
        end
    end

    // Sends one transaction, leaving tvalid high when the next follows at once.
    task automatic send_op(input t_op op, input logic [31:0] v, input bit keep);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, v, 4'(op)};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(op, v);
        sent_count++;
        if (!keep) s_axis_tvalid <= 1'b0;
    endtask

    // A single transaction followed by a gap with tvalid low.
    task automatic send_burst(input t_op op, input logic [31:0] v);
        send_op(op, v, 1'b0);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 40);
            4: return -$urandom_range(0, 40);
            5: return $urandom_range(0, 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op rand_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 38) return OP_PUSH;
        if (r < 47) return OP_ADD;
        if (r < 55) return OP_SUB;
        if (r < 63) return OP_MUL;
        if (r < 73) return OP_DIV;
        if (r < 80) return OP_LN;
        if (r < 88) return OP_LOG;
        if (r < 92) return OP_PI;
        if (r < 96) return OP_E;
        return t_op'($urandom_range(9, 15));
    endfunction

    initial begin
        int unsigned burst;
        t_op op;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: underflow on empty stack, extremes, each operation and error.
        send_burst(OP_ADD, 32'd0);
        send_burst(OP_LN, 32'd0);
        send_burst(OP_PUSH, 32'h8000_0000);
        send_burst(OP_PUSH, 32'hFFFF_FFFF);
        send_burst(OP_DIV, 32'd0);
        send_burst(OP_PUSH, 32'h7FFF_FFFF);
        send_burst(OP_PUSH, 32'h7FFF_FFFF);
        send_burst(OP_MUL, 32'd0);
        send_burst(OP_PUSH, 32'd5);
        send_burst(OP_PUSH, 32'd0);
        send_burst(OP_DIV, 32'd0);
        send_burst(OP_PUSH, 32'd1000);
        send_burst(OP_PUSH, 32'd10);
        send_burst(OP_LOG, 32'd0);
        send_burst(OP_PUSH, 32'd1);
        send_burst(OP_LOG, 32'd0);
        send_burst(OP_PUSH, 32'h7FFF_FFFF);
        send_burst(OP_LN, 32'd0);
        send_burst(OP_PUSH, 32'h8000_0001);
        send_burst(OP_LN, 32'd0);
        send_burst(OP_PI, 32'd0);
        send_burst(OP_E, 32'd0);
        send_burst(OP_SUB, 32'd0);
        send_burst(t_op'(4'd15), 32'hA5A5_A5A5);
        for (int i = 0; i < 18; i++) send_op(OP_PI, 32'd0, i != 17);

        // Hold off the sender until every outstanding result is back.
        while (board.report_q.size() != 0) @(posedge i_clk);

        // Random bursts with gaps; every so often wait for the pipe to drain.
        while (sent_count < 1340) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++) begin
                op = rand_op();
                send_op(op, rand_value(), i != burst - 1);
            end
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            if ($urandom_range(0, 40) == 0)
                while (board.report_q.size() != 0) @(posedge i_clk);
        end

        while (board.report_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Sent %0d stack operations covering all ops, errors and depth limits;",
                 sent_count);
        $display("checked %0d reports under random source gaps and sink stalls.",
                 board.report_count);
        if (board.fail_count == 0 && board.report_q.size() == 0)
            $display("rpn_stack_alu verification clean");
        else
            $display("rpn_stack_alu verification failed");
        $finish;
    end
endmodule

`default_nettype wire
